// ----- rtl/nps_pkg.sv -----
// Package for the nearest palette color search block.
// Holds the palette size, derived widths and the controller state type.
// No dependencies.
package nps_pkg;

  // Number of palette entries held in the store.
  localparam int unsigned PALETTE_ENTRIES = 256;

  // Width of a store address.
  localparam int unsigned ENTRY_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // The entry whose packed word carries alpha zero.
  localparam logic [7:0] TRANSPARENT_ENTRY = 8'd255;

  // Squared distance needs 18 bits: 3 * 255^2 = 195075.
  localparam int unsigned DIST_W = 18;

  // Command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } nps_state_e;

endpackage

// ----- rtl/nearest_palette_color_search.sv -----
// Nearest palette color search, top level.
// Holds the palette memory, the scan pipeline and the output register.
// Depends on nps_pkg.

// A write request stores one 24-bit RGB entry and returns its packed ABGR
// word (alpha 255, or 0 for entry 255) through the output register. A
// lookup request expands its RGB555 color to 8 bits per component (c*8+4)
// and scans the whole palette, one memory read per entry per cycle, through
// a three-stage pipeline of read, square and accumulate-compare. The result
// (the lowest index of least squared distance) is registered once the last
// entry has been compared; the single read port of the palette memory sets
// the length of the scan. One request is in flight at a time: a new request
// is accepted once the block is idle and its output register is empty or
// being emptied in the same cycle. Lookups are only meaningful after every
// entry has been written.
module nearest_palette_color_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [14:0] color_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] packed_word_o,
  output logic [7:0]  nearest_index_o
);
  import nps_pkg::*;

  localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(PALETTE_ENTRIES - 1);

  nps_state_e state_q, state_d;

  logic               in_fire;
  logic               wr_en;
  logic               lookup_start;
  logic [ENTRY_W-1:0] issue_cnt_q;
  logic               issue_en_q;

  // Palette memory and its registered read data.
  logic [23:0]        mem [PALETTE_ENTRIES];
  logic [23:0]        rd_data_q;

  // Pipeline valid bits and index tags.
  logic               v1_q, v2_q;
  logic [ENTRY_W-1:0] idx1_q, idx2_q;

  // Expanded lookup color.
  logic [7:0]         col_r_q, col_g_q, col_b_q;

  // Squared component differences.
  logic [15:0]        sq_r_q, sq_g_q, sq_b_q;
  logic [7:0]         dr, dg, db;

  // Running best.
  logic [DIST_W-1:0]  best_dist_q;
  logic [ENTRY_W-1:0] best_idx_q;
  logic [DIST_W-1:0]  cand_dist;
  logic               better;
  logic [ENTRY_W-1:0] final_idx;
  logic               scan_done;

  // Output register.
  logic               out_valid_q;
  logic [31:0]        packed_word_q;
  logic [7:0]         nearest_index_q;

  // Handshake and request decode.
  assign in_ready_o   = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire      = in_valid_i && in_ready_o;
  assign wr_en        = in_fire && (cmd_i == CMD_WRITE) &&
                        ({1'b0, entry_index_i} < 9'(PALETTE_ENTRIES));
  assign lookup_start = in_fire && (cmd_i == CMD_LOOKUP);
  assign scan_done    = v2_q && (idx2_q == LAST_ENTRY);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (lookup_start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Palette memory: one write port, one registered read port. Writes happen
  // only while idle, so they never overlap a scan.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[entry_index_i[ENTRY_W-1:0]] <= {blue_i, green_i, red_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[issue_cnt_q];
  end

  // Read address issue and pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_cnt_q <= '0;
      issue_en_q  <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
    end else begin
      if (lookup_start) begin
        issue_cnt_q <= '0;
        issue_en_q  <= 1'b1;
      end else if (issue_en_q) begin
        if (issue_cnt_q == LAST_ENTRY) begin
          issue_en_q <= 1'b0;
        end else begin
          issue_cnt_q <= issue_cnt_q + 1'b1;
        end
      end
      v1_q <= issue_en_q;
      v2_q <= v1_q;
    end
  end

  // Capture the expanded lookup color at acceptance.
  always_ff @(posedge clk_i) begin
    if (lookup_start) begin
      col_r_q <= {color_word_i[4:0], 3'b100};
      col_g_q <= {color_word_i[9:5], 3'b100};
      col_b_q <= {color_word_i[14:10], 3'b100};
    end
  end

  // Stage one: absolute differences, squared and registered.
  always_comb begin
    dr = (col_r_q >= rd_data_q[7:0])   ? col_r_q - rd_data_q[7:0]
                                       : rd_data_q[7:0] - col_r_q;
    dg = (col_g_q >= rd_data_q[15:8])  ? col_g_q - rd_data_q[15:8]
                                       : rd_data_q[15:8] - col_g_q;
    db = (col_b_q >= rd_data_q[23:16]) ? col_b_q - rd_data_q[23:16]
                                       : rd_data_q[23:16] - col_b_q;
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= issue_cnt_q;
    idx2_q <= idx1_q;
    sq_r_q <= 16'(dr) * 16'(dr);
    sq_g_q <= 16'(dg) * 16'(dg);
    sq_b_q <= 16'(db) * 16'(db);
  end

  // Stage two: total distance against the running best. A strict compare
  // keeps the lowest index on a tie.
  assign cand_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  assign better    = cand_dist < best_dist_q;
  assign final_idx = better ? idx2_q : best_idx_q;

  always_ff @(posedge clk_i) begin
    if (lookup_start) begin
      best_dist_q <= '1;
      best_idx_q  <= '0;
    end else if (v2_q && better) begin
      best_dist_q <= cand_dist;
      best_idx_q  <= idx2_q;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_fire && (cmd_i == CMD_WRITE)) || scan_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (in_fire && (cmd_i == CMD_WRITE)) begin
      packed_word_q   <= {(entry_index_i == TRANSPARENT_ENTRY) ? 8'h00 : 8'hFF,
                          blue_i, green_i, red_i};
      nearest_index_q <= '0;
    end else if (scan_done) begin
      packed_word_q   <= '0;
      nearest_index_q <= 8'(final_idx);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packed_word_o   = packed_word_q;
  assign nearest_index_o = nearest_index_q;

  // The output register stays empty for the whole scan.
  a_no_result_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !scan_done) |=> (state_q != ST_SCAN) || !out_valid_o)
    else $error("result appeared in the middle of a scan");

  // A request is never taken during a scan.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("ready raised while scanning");

  // The end of a scan delivers a result and returns to idle.
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |=> out_valid_o && state_q == ST_IDLE)
    else $error("scan end did not produce a result");

  // The memory is never written while entries are being read out.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !issue_en_q && !v1_q && !v2_q)
    else $error("palette write overlapped a scan");

endmodule

// ----- tb/tb_nearest_palette_color_search.sv -----
// Self-checking testbench for the nearest palette color search block.
// Fills the palette, then mixes directed and random write and lookup requests.
// Depends on nps_pkg and nearest_palette_color_search.
module tb_nearest_palette_color_search;
  timeunit 1ns;
  timeprecision 1ps;

  import nps_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS   = 1330;
  localparam int unsigned STEADY_TAIL    = 150;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] cw;
    logic        hold;    // wait for every outstanding result before sending
    logic        steady;  // no idling from this request on
  } request_t;

  typedef struct packed {
    logic [31:0] word;
    logic [7:0]  index;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_ready_o;
  request_t drv_req = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  logic [31:0] packed_word_o;
  logic [7:0]  nearest_index_o;

  // Shared state between stimulus, driver and monitor.
  request_t    requests_todo[$];
  answer_t     answers_due[$];
  logic [23:0] palette_shadow [PALETTE_ENTRIES];
  logic [23:0] planned_palette [256];
  int unsigned accepted_cnt = 0;
  int unsigned answered_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  logic        quiet_phase = 1'b0;

  always #6 clk_i = ~clk_i;

  nearest_palette_color_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .cmd_i           (drv_req.cmd),
    .entry_index_i   (drv_req.idx),
    .red_i           (drv_req.red),
    .green_i         (drv_req.green),
    .blue_i          (drv_req.blue),
    .color_word_i    (drv_req.cw),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .packed_word_o   (packed_word_o),
    .nearest_index_o (nearest_index_o)
  );

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Index of the palette entry closest to an RGB555 color; lowest index on a tie.
  function automatic logic [7:0] closest_entry(input logic [14:0] cw);
    int unsigned r, g, b, er, eg, eb, sum_sq, best_dist;
    int unsigned i;
    logic [7:0] best;
    r = 32'({cw[4:0], 3'b100});
    g = 32'({cw[9:5], 3'b100});
    b = 32'({cw[14:10], 3'b100});
    best = '0;
    best_dist = 32'hFFFF_FFFF;
    for (i = 0; i < PALETTE_ENTRIES; i++) begin
      er = 32'(palette_shadow[i][7:0]);
      eg = 32'(palette_shadow[i][15:8]);
      eb = 32'(palette_shadow[i][23:16]);
      sum_sq = (r - er) * (r - er) + (g - eg) * (g - eg) + (b - eb) * (b - eb);
      if (sum_sq < best_dist) begin
        best_dist = sum_sq;
        best = i[7:0];
      end
    end
    return best;
  endfunction

  // Apply an accepted request to the shadow palette and queue its result.
  task automatic predict_answer(input request_t rq);
    answer_t ans;
    ans = '0;
    if (rq.cmd == CMD_WRITE) begin
      ans.word = {(rq.idx == TRANSPARENT_ENTRY) ? 8'h00 : 8'hFF, rq.blue, rq.green, rq.red};
      if (rq.idx < PALETTE_ENTRIES) begin
        palette_shadow[rq.idx] = {rq.blue, rq.green, rq.red};
      end
    end else begin
      ans.index = closest_entry(rq.cw);
    end
    answers_due.push_back(ans);
  endtask

  // Driver: presents queued requests with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic     fire;
    request_t head;
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      drv_req      <= '0;
      send_gap     <= 0;
      accepted_cnt <= 0;
      quiet_phase  <= 1'b0;
    end else begin
      fire = in_valid && in_ready_o;
      if (fire) begin
        predict_answer(drv_req);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || fire) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (requests_todo.size() != 0 &&
                     !(requests_todo[0].hold && (fire || answered_cnt != accepted_cnt))) begin
          head = requests_todo.pop_front();
          drv_req  <= head;
          in_valid <= 1'b1;
          if (head.steady) begin
            quiet_phase <= 1'b1;
          end
          if (!head.steady && $urandom_range(0, 3) == 0) begin
            send_gap <= $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result side at random and checks every result in order.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    answer_t want;
    if (!rst_ni) begin
      out_ready    <= 1'b0;
      stall_left   <= 0;
      answered_cnt <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        answered_cnt <= answered_cnt + 1;
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word=%h index=%0d",
                                  packed_word_o, nearest_index_o));
        end else begin
          want = answers_due.pop_front();
          if (packed_word_o !== want.word) begin
            flag_mismatch($sformatf("packed_word %h, expected %h", packed_word_o, want.word));
          end
          if (nearest_index_o !== want.index) begin
            flag_mismatch($sformatf("nearest_index %0d, expected %0d",
                                    nearest_index_o, want.index));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no request or result moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Queue a write request; the lookup color field carries junk.
  task automatic add_write(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    request_t rq;
    rq = '0;
    rq.cmd   = CMD_WRITE;
    rq.idx   = idx;
    rq.red   = r;
    rq.green = g;
    rq.blue  = b;
    rq.cw    = 15'($urandom_range(0, 32767));
    planned_palette[idx] = {b, g, r};
    requests_todo.push_back(rq);
  endtask

  // Queue a lookup request; the write fields carry junk.
  task automatic add_lookup(input logic [14:0] cw);
    request_t rq;
    rq = '0;
    rq.cmd   = CMD_LOOKUP;
    rq.idx   = 8'($urandom_range(0, 255));
    rq.red   = 8'($urandom_range(0, 255));
    rq.green = 8'($urandom_range(0, 255));
    rq.blue  = 8'($urandom_range(0, 255));
    rq.cw    = cw;
    requests_todo.push_back(rq);
  endtask

  // Stimulus, end-of-run wait and final verdict.
  initial begin : stimulus
    int unsigned i, k, src, total;
    logic [23:0] c;
    logic [4:0]  q0, q1, q2;

    // Fill every entry first so no lookup reads an unwritten entry.
    for (i = 0; i < 256; i++) begin
      add_write(i[7:0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end

    // Directed: transparent entry, extremes, exact matches and ties.
    add_write(8'd255, 8'hFF, 8'hFF, 8'hFF);
    add_write(8'd0, 8'h00, 8'h00, 8'h00);
    add_write(8'd60, 8'd6, 8'd4, 8'd4);
    add_write(8'd30, 8'd2, 8'd4, 8'd4);
    add_lookup(15'h0000);
    add_write(8'd200, 8'd4, 8'd4, 8'd4);
    add_write(8'd201, 8'd4, 8'd4, 8'd4);
    add_lookup(15'h0000);
    add_write(8'd128, 8'd132, 8'd4, 8'd252);
    add_lookup({5'd31, 5'd0, 5'd16});
    add_lookup(15'h7FFF);
    add_write(8'd254, 8'hFF, 8'h00, 8'hFF);
    add_write(8'd1, 8'h00, 8'hFF, 8'h00);
    add_lookup(15'h001F);
    add_lookup(15'h03E0);
    add_lookup(15'h7C00);

    // Random mix of writes and lookups, with ties and exact hits provoked.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      k = $urandom_range(0, 9);
      case (k)
        0, 1, 2: begin
          add_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        3: begin
          src = $urandom_range(0, 255);
          c = planned_palette[src];
          add_write(8'($urandom_range(0, 255)), c[7:0], c[15:8], c[23:16]);
        end
        4: begin
          q0 = 5'($urandom_range(0, 31));
          q1 = 5'($urandom_range(0, 31));
          q2 = 5'($urandom_range(0, 31));
          add_write(8'($urandom_range(0, 255)), {q0, 3'b100}, {q1, 3'b100}, {q2, 3'b100});
        end
        8: begin
          src = $urandom_range(0, 255);
          c = planned_palette[src];
          add_lookup({c[23:19], c[15:11], c[7:3]});
        end
        9: begin
          q0 = $urandom_range(0, 1) ? 5'd31 : 5'd0;
          q1 = 5'($urandom_range(0, 31));
          q2 = $urandom_range(0, 1) ? 5'd31 : 5'd0;
          add_lookup({q2, q1, q0});
        end
        default: begin
          add_lookup(15'($urandom_range(0, 32767)));
        end
      endcase
    end

    // Pause the sender until the block has drained at a few points.
    total = requests_todo.size();
    requests_todo[256].hold = 1'b1;
    requests_todo[total / 2].hold = 1'b1;
    requests_todo[total - 400].hold = 1'b1;
    for (i = total - STEADY_TAIL; i < total; i++) begin
      requests_todo[i].steady = 1'b1;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_todo.size() != 0 || in_valid || answers_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (answers_due.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", answers_due.size()));
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
